@@ rtl/core/sct_pkg.sv @@
`timescale 1ns / 1ps
package sct_pkg;
    localparam int SLOTS = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        FUNC_REGISTER = 2'd0,
        FUNC_UPDATE   = 2'd1,
        FUNC_RIGID    = 2'd2,
        FUNC_REMOVE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_BAD   = 2'd2,
        STATUS_SPARE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] obj_type;
        logic [14:0] radius;
        logic signed [15:0] cz;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } entry_t;
endpackage

@@ rtl/core/sphere_collision_table_unit.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Bits  Contents (low bit up)
// s_axis   in   88    func[1:0] slot[7:2] cx[23:8] cy[39:24] cz[55:40] radius[70:56]
//                     obj_type[86:71] rigid_flag[87]
// m_axis   out  32    slot_out[5:0] hit_types[21:6] enter[22] stay[23] leave[24] status[26:25]
// Register, set rigid, remove and an update that is refused or finds its slot rigid load
// the result in the read state and raise it from the output state. Any other update passes
// a read state, the scan that reads one table entry per cycle, a drain of the two-stage
// distance pipeline, the flag write-back and the result load.
// Reset clears the valid bits and the control state; memories are unset.
// The result register holds until taken; the next beat is accepted in the cycle after that.
module sphere_collision_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // func, slot, cx, cy, cz, radius, obj_type, rigid_flag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // slot_out, hit_types, enter, stay, leave, status
);
    localparam int SW = sct_pkg::SLOT_W;
    localparam int CW = sct_pkg::CNT_W;

    sct_pkg::entry_t mem [sct_pkg::SLOTS];
    logic [3:0] flag_mem [sct_pkg::SLOTS];
    logic rigid_mem [sct_pkg::SLOTS];
    logic [sct_pkg::SLOTS-1:0] valid_reg, valid_next;

    sct_pkg::state_t state_reg, state_next;
    logic [1:0]  func_reg;
    logic [SW-1:0] slot_reg;
    logic [5:0]  slot_in_reg;
    logic signed [15:0] cx_reg, cy_reg, cz_reg;
    logic [14:0] rad_reg;
    logic [15:0] type_reg;
    logic        rflag_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        rd_v_reg;
    logic [SW-1:0] rd_idx_reg;
    sct_pkg::entry_t rd_reg;
    sct_pkg::entry_t own_reg;
    logic [3:0]  fl_rd_reg;
    logic        rg_rd_reg;
    logic        p_v_reg;
    logic [15:0] p_type_reg;
    logic [33:0] sq_reg [3];
    logic [31:0] rs2_reg;
    logic [15:0] hits_reg;
    logic        any_reg;
    logic [31:0] out_reg, out_next;
    logic        out_v_reg;
    logic        sel_ok;
    logic [SW-1:0] free_idx;
    logic        free_any;

    assign s_axis_tready = (state_reg == sct_pkg::ST_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = out_reg;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = sct_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign sel_ok = ({{(6-SW+1){1'b0}}, slot_reg} == {1'b0, slot_in_reg})
                    && valid_reg[slot_reg];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sct_pkg::ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_next = sct_pkg::ST_READ;
            sct_pkg::ST_READ:
                if (func_reg == sct_pkg::FUNC_UPDATE && sel_ok && !rg_rd_reg)
                    state_next = sct_pkg::ST_SCAN;
                else
                    state_next = sct_pkg::ST_OUT;
            sct_pkg::ST_SCAN:  if (cnt_reg == CW'(sct_pkg::SLOTS - 1)) state_next = sct_pkg::ST_DRAIN;
            sct_pkg::ST_DRAIN: if (!rd_v_reg && !p_v_reg) state_next = sct_pkg::ST_WRITE;
            sct_pkg::ST_WRITE: state_next = sct_pkg::ST_OUT;
            sct_pkg::ST_OUT:   state_next = sct_pkg::ST_IDLE;
            default:           state_next = sct_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == sct_pkg::ST_READ) cnt_next = '0;
        else if (state_reg == sct_pkg::ST_SCAN) cnt_next = cnt_reg + CW'(1);
    end

    // valid bits
    always_comb
    begin
        valid_next = valid_reg;
        if (state_reg == sct_pkg::ST_READ)
        begin
            if (func_reg == sct_pkg::FUNC_REGISTER && free_any) valid_next[free_idx] = 1'b1;
            else if (func_reg == sct_pkg::FUNC_REMOVE && sel_ok) valid_next[slot_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sct_pkg::ST_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            rd_v_reg  <= 1'b0;
            p_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            rd_v_reg  <= (state_reg == sct_pkg::ST_SCAN);
            p_v_reg   <= rd_v_reg && rd_idx_reg != slot_reg && valid_reg[rd_idx_reg];
            if (state_reg == sct_pkg::ST_OUT) out_v_reg <= 1'b1;
            else if (m_axis_tready) out_v_reg <= 1'b0;
        end
    end

    // capture beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg    <= s_axis_tdata[1:0];
            slot_in_reg <= s_axis_tdata[7:2];
            slot_reg    <= SW'(s_axis_tdata[7:2]);
            cx_reg      <= s_axis_tdata[23:8];
            cy_reg      <= s_axis_tdata[39:24];
            cz_reg      <= s_axis_tdata[55:40];
            rad_reg     <= s_axis_tdata[70:56];
            type_reg    <= s_axis_tdata[86:71];
            rflag_reg   <= s_axis_tdata[87];
        end
    end

    // entry memory: synchronous read, writes by register and update
    always_ff @(posedge clk)
    begin
        if (state_reg == sct_pkg::ST_IDLE) own_reg <= mem[SW'(s_axis_tdata[7:2])];
        if (state_reg == sct_pkg::ST_SCAN)
        begin
            rd_reg     <= mem[cnt_reg[SW-1:0]];
            rd_idx_reg <= cnt_reg[SW-1:0];
        end
        if (state_reg == sct_pkg::ST_READ && func_reg == sct_pkg::FUNC_REGISTER && free_any)
            mem[free_idx] <= '{type_reg, rad_reg, cz_reg, cy_reg, cx_reg};
        else if (state_reg == sct_pkg::ST_READ && func_reg == sct_pkg::FUNC_UPDATE && sel_ok
                 && !rg_rd_reg)
            mem[slot_reg] <= '{own_reg.obj_type, own_reg.radius, cz_reg, cy_reg, cx_reg};
    end

    // flag and rigid memories
    always_ff @(posedge clk)
    begin
        if (state_reg == sct_pkg::ST_IDLE)
        begin
            fl_rd_reg <= flag_mem[SW'(s_axis_tdata[7:2])];
            rg_rd_reg <= rigid_mem[SW'(s_axis_tdata[7:2])];
        end
        if (state_reg == sct_pkg::ST_READ && func_reg == sct_pkg::FUNC_REGISTER && free_any)
        begin
            flag_mem[free_idx]  <= 4'd0;
            rigid_mem[free_idx] <= 1'b0;
        end
        if (state_reg == sct_pkg::ST_READ && func_reg == sct_pkg::FUNC_RIGID && sel_ok)
            rigid_mem[slot_reg] <= rflag_reg;
        if (state_reg == sct_pkg::ST_WRITE)
            flag_mem[slot_reg] <= {any_reg, 1'b0, any_reg, 1'b0} |
                                  {1'b0, !any_reg && fl_rd_reg[3], 1'b0,
                                   any_reg && !fl_rd_reg[3]};
    end

    // distance pipeline: squares, then compare
    logic signed [16:0] dx, dy, dz;
    logic [15:0] rsum;
    assign dx = 17'(cx_reg) - 17'(rd_reg.cx);
    assign dy = 17'(cy_reg) - 17'(rd_reg.cy);
    assign dz = 17'(cz_reg) - 17'(rd_reg.cz);
    assign rsum = 16'(own_reg.radius) + 16'(rd_reg.radius);

    always_ff @(posedge clk)
    begin
        sq_reg[0]  <= 34'(dx * dx);
        sq_reg[1]  <= 34'(dy * dy);
        sq_reg[2]  <= 34'(dz * dz);
        rs2_reg    <= rsum * rsum;
        p_type_reg <= rd_reg.obj_type;
        if (state_reg == sct_pkg::ST_READ)
        begin
            hits_reg <= '0;
            any_reg  <= 1'b0;
        end
        else if (p_v_reg &&
                 (36'(sq_reg[0]) + 36'(sq_reg[1]) + 36'(sq_reg[2]) <= 36'(rs2_reg)))
        begin
            hits_reg <= hits_reg | p_type_reg;
            any_reg  <= 1'b1;
        end
    end

    // assemble result beat
    always_comb
    begin
        out_next = out_reg;
        if (state_reg == sct_pkg::ST_READ)
        begin
            out_next = '0;
            if (func_reg == sct_pkg::FUNC_REGISTER)
            begin
                out_next[5:0]   = free_any ? 6'(free_idx) : 6'd0;
                out_next[26:25] = free_any ? sct_pkg::STATUS_OK : sct_pkg::STATUS_FULL;
            end
            else
            begin
                out_next[5:0] = slot_in_reg;
                if (!sel_ok) out_next[26:25] = sct_pkg::STATUS_BAD;
                else if (func_reg == sct_pkg::FUNC_UPDATE && rg_rd_reg)
                    out_next[24:22] = {fl_rd_reg[2], fl_rd_reg[1], fl_rd_reg[0]};
            end
        end
        else if (state_reg == sct_pkg::ST_WRITE)
        begin
            out_next[21:6] = hits_reg;
            out_next[22]   = any_reg && !fl_rd_reg[3];
            out_next[23]   = any_reg;
            out_next[24]   = !any_reg && fl_rd_reg[3];
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sct_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("beat accepted while busy");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sct_pkg::ST_OUT) |=> m_axis_tvalid)
        else $error("result not raised");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[22] && m_axis_tdata[24]))
        else $error("enter and leave together");
`endif
endmodule

@@ dv/sphere_collision_table_checker.sv @@
`timescale 1ns / 1ps
module sphere_collision_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count
);
    localparam logic [3:0] FL_ENTER = 4'd1;
    localparam logic [3:0] FL_STAY  = 4'd2;
    localparam logic [3:0] FL_LEAVE = 4'd4;
    localparam logic [3:0] FL_PAST  = 4'd8;

    typedef struct packed {
        logic [1:0]  status;
        logic        leave;
        logic        stay;
        logic        enter;
        logic [15:0] hit_types;
        logic [5:0]  slot_out;
    } answer_t;

    // Shadow copy of the sphere table
    logic               tbl_valid [sct_pkg::SLOTS];
    logic signed [15:0] tbl_cx [sct_pkg::SLOTS];
    logic signed [15:0] tbl_cy [sct_pkg::SLOTS];
    logic signed [15:0] tbl_cz [sct_pkg::SLOTS];
    logic [14:0]        tbl_rad [sct_pkg::SLOTS];
    logic [15:0]        tbl_type [sct_pkg::SLOTS];
    logic               tbl_rigid [sct_pkg::SLOTS];
    logic [3:0]         tbl_flags [sct_pkg::SLOTS];

    answer_t answer_queue[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic logic spheres_touch(int a, int b);
        longint dx, dy, dz, rs;
        dx = longint'(tbl_cx[a]) - longint'(tbl_cx[b]);
        dy = longint'(tbl_cy[a]) - longint'(tbl_cy[b]);
        dz = longint'(tbl_cz[a]) - longint'(tbl_cz[b]);
        rs = longint'(tbl_rad[a]) + longint'(tbl_rad[b]);
        return (dx * dx + dy * dy + dz * dz) <= rs * rs;
    endfunction

    // Apply one command beat to the shadow table and compute its answer
    function automatic answer_t apply_command(logic [87:0] d);
        answer_t a;
        sct_pkg::func_t f;
        int s;
        logic any, past;
        logic [3:0] fl;
        a = '0;
        f = sct_pkg::func_t'(d[1:0]);
        s = int'(d[7:2]);
        a.slot_out = d[7:2];
        if (f == sct_pkg::FUNC_REGISTER)
        begin
            a.slot_out = '0;
            a.status = sct_pkg::STATUS_FULL;
            for (int i = 0; i < sct_pkg::SLOTS; i++)
            begin
                if (!tbl_valid[i])
                begin
                    tbl_valid[i] = 1'b1;
                    tbl_cx[i] = d[23:8];
                    tbl_cy[i] = d[39:24];
                    tbl_cz[i] = d[55:40];
                    tbl_rad[i] = d[70:56];
                    tbl_type[i] = d[86:71];
                    tbl_rigid[i] = 1'b0;
                    tbl_flags[i] = '0;
                    a.slot_out = i[5:0];
                    a.status = sct_pkg::STATUS_OK;
                    break;
                end
            end
        end
        else if (!tbl_valid[s])
        begin
            a.status = sct_pkg::STATUS_BAD;
        end
        else if (f == sct_pkg::FUNC_UPDATE)
        begin
            if (tbl_rigid[s])
            begin
                a.enter = |(tbl_flags[s] & FL_ENTER);
                a.stay  = |(tbl_flags[s] & FL_STAY);
                a.leave = |(tbl_flags[s] & FL_LEAVE);
            end
            else
            begin
                any = 1'b0;
                tbl_cx[s] = d[23:8];
                tbl_cy[s] = d[39:24];
                tbl_cz[s] = d[55:40];
                for (int i = 0; i < sct_pkg::SLOTS; i++)
                begin
                    if (i != s && tbl_valid[i] && spheres_touch(s, i))
                    begin
                        any = 1'b1;
                        a.hit_types |= tbl_type[i];
                    end
                end
                past = |(tbl_flags[s] & FL_PAST);
                a.stay = any;
                a.enter = any && !past;
                a.leave = !any && past;
                fl = '0;
                if (a.enter) fl |= FL_ENTER;
                if (a.stay) fl |= FL_STAY | FL_PAST;
                if (a.leave) fl |= FL_LEAVE;
                tbl_flags[s] = fl;
            end
        end
        else if (f == sct_pkg::FUNC_RIGID)
        begin
            tbl_rigid[s] = d[87];
        end
        else
        begin
            tbl_valid[s] = 1'b0;
        end
        return a;
    endfunction

    // Predict on each command beat, compare on each answer beat
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want, got;
        if (!rst_n)
        begin
            fail_count = 0;
            pending_count = 0;
            answer_queue.delete();
            for (int i = 0; i < sct_pkg::SLOTS; i++)
                tbl_valid[i] = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[26:0];
                if (answer_queue.size() == 0)
                    report_mismatch("unexpected beat", m_axis_tdata, '0);
                else
                begin
                    want = answer_queue.pop_front();
                    if (got.slot_out !== want.slot_out)
                        report_mismatch("slot_out", 32'(got.slot_out), 32'(want.slot_out));
                    if (got.hit_types !== want.hit_types)
                        report_mismatch("hit_types", 32'(got.hit_types), 32'(want.hit_types));
                    if (got.enter !== want.enter)
                        report_mismatch("enter", 32'(got.enter), 32'(want.enter));
                    if (got.stay !== want.stay)
                        report_mismatch("stay", 32'(got.stay), 32'(want.stay));
                    if (got.leave !== want.leave)
                        report_mismatch("leave", 32'(got.leave), 32'(want.leave));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                answer_queue.insert(answer_queue.size(), apply_command(s_axis_tdata));
            pending_count = answer_queue.size();
        end
    end
endmodule

@@ dv/sphere_collision_table_unit_tb.sv @@
`timescale 1ns / 1ps
module sphere_collision_table_unit_tb;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          cycle_count;
    logic [sct_pkg::SLOTS-1:0] live;

    sphere_collision_table_unit dut (.*);

    sphere_collision_table_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 600000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [87:0] pack_cmd(sct_pkg::func_t f, logic [5:0] s, logic [15:0] x,
                                             logic [15:0] y, logic [15:0] z,
                                             logic [14:0] r, logic [15:0] t, logic rg);
        return {rg, t, r, z, y, x, s, f};
    endfunction

    task automatic send_cmd(logic [87:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // track which slots the sender believes are live
        if (d[1:0] == sct_pkg::FUNC_REGISTER)
        begin
            for (int i = 0; i < sct_pkg::SLOTS; i++)
                if (!live[i])
                begin
                    live[i] = 1'b1;
                    break;
                end
        end
        else if (d[1:0] == sct_pkg::FUNC_REMOVE)
            live[d[7:2]] = 1'b0;
    endtask

    task automatic send_random(int n);
        sct_pkg::func_t f;
        logic [5:0] s;
        logic [15:0] x, y, z;
        int pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 25) f = sct_pkg::FUNC_REGISTER;
            else if (pick < 75) f = sct_pkg::FUNC_UPDATE;
            else if (pick < 85) f = sct_pkg::FUNC_RIGID;
            else f = sct_pkg::FUNC_REMOVE;
            s = 6'($urandom_range(sct_pkg::SLOTS - 1));
            // mostly address a live slot
            if ($urandom_range(9) < 8 && live != '0)
                while (!live[s])
                    s = 6'($urandom_range(sct_pkg::SLOTS - 1));
            // cluster centers near the origin so spheres meet often
            if ($urandom_range(3) == 0)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
                z = 16'($urandom);
            end
            else
            begin
                x = $signed(16'($urandom_range(2047))) - 16'sd1024;
                y = $signed(16'($urandom_range(2047))) - 16'sd1024;
                z = $signed(16'($urandom_range(2047))) - 16'sd1024;
            end
            send_cmd(pack_cmd(f, s, x, y, z,
                              ($urandom_range(3) == 0) ? 15'($urandom) :
                              15'($urandom_range(1023)),
                              16'($urandom), $urandom_range(9) < 2));
        end
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (sct_pkg::SLOTS + 10) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        hold_off = 1'b0;
        live = '0;
        send_idle_pct = 26;
        recv_idle_pct = 74;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operations on an empty table, then extremes
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd0, '0, '0, '0, '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_RIGID, 6'd63, '0, '0, '0, '0, '0, 1'b1));
        send_cmd(pack_cmd(sct_pkg::FUNC_REMOVE, 6'd5, '0, '0, '0, '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_REGISTER, 6'd0, 16'h7fff, 16'h7fff, 16'h7fff,
                          15'h7fff, 16'hffff, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_REGISTER, 6'd0, 16'h8000, 16'h8000, 16'h8000,
                          15'h7fff, 16'h0000, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_REGISTER, 6'd0, '0, '0, '0, 15'd0, 16'h0001, 1'b0));
        // far corners at max radii: no touch across the diagonal, a touch from the origin, then a leave
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd0, 16'h7fff, 16'h7fff, 16'h7fff,
                          '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd1, '0, '0, '0, '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd1, 16'h8000, 16'h8000, 16'h8000,
                          '0, '0, 1'b0));
        // slot 2 enters, then rigid slot 1 reports its old flags
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd2, 16'h4000, 16'h4000, 16'h4000,
                          '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_RIGID, 6'd1, '0, '0, '0, '0, '0, 1'b1));
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd1, 16'h1234, 16'h1234, 16'h1234,
                          '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_RIGID, 6'd1, '0, '0, '0, '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd1, 16'h4000, 16'h4000, 16'h4000,
                          '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_REMOVE, 6'd0, '0, '0, '0, '0, '0, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_UPDATE, 6'd0, '0, '0, '0, '0, '0, 1'b0));
        // fill the table, hit table full, then free one slot
        for (int i = 0; i < sct_pkg::SLOTS; i++)
            send_cmd(pack_cmd(sct_pkg::FUNC_REGISTER, '0, 16'(i * 64), 16'(i * 32), '0,
                              15'd40, 16'(1 << (i % 16)), 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_REGISTER, '0, '0, '0, '0, 15'd1, 16'h1, 1'b0));
        send_cmd(pack_cmd(sct_pkg::FUNC_REMOVE, 6'd30, '0, '0, '0, '0, '0, 1'b0));
        wait_drained();

        // Long receiver hold-off while the sender keeps offering beats
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(20);
        join
        send_random(330);
        wait_drained();

        send_idle_pct = 74;
        recv_idle_pct = 26;
        for (int i = 0; i < sct_pkg::SLOTS; i++)
            if (live[i])
                send_cmd(pack_cmd(sct_pkg::FUNC_REMOVE, 6'(i), '0, '0, '0, '0, '0, 1'b0));
        send_random(350);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(300);
        wait_drained();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/sct_pkg.sv
rtl/core/sphere_collision_table_unit.sv
dv/sphere_collision_table_checker.sv
dv/sphere_collision_table_unit_tb.sv
